/* design/dfd_pkg.sv */
// Shared types and constants for the delimited frame deframer.
// Used by every module of the block; it depends on nothing else.
package dfd_pkg;

  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned OutDataW = 64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_START_VALUE = 8'd0,
    CFG_END_VALUE   = 8'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_START = 2'd1,
    ST_SHORT     = 2'd2,
    ST_BAD_END   = 2'd3
  } status_e;

  typedef enum logic [4:0] {
    PH_START   = 5'b00001,
    PH_HEADER  = 5'b00010,
    PH_PAYLOAD = 5'b00100,
    PH_END     = 5'b01000,
    PH_IGNORE  = 5'b10000
  } phase_e;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_STATUS  = 1'b1;

  typedef struct packed {
    logic [7:0] start_value;
    logic [7:0] end_value;
  } cfg_t;

  typedef struct packed {
    logic       buffer_end;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  payload_byte;
    status_e     status;
    logic [31:0] stamp;
    logic [15:0] payload_length;
  } res_t;

endpackage

/* design/dfd_in_stage.sv */
// Input register of the deframer: holds one received byte and its end mark.
// Depends on dfd_pkg for the item type.
module dfd_in_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  output logic          ready_o,
  input  dfd_pkg::item_t item_i,
  output logic          valid_o,
  input  logic          take_i,
  output dfd_pkg::item_t item_o
);

  logic           valid_q;
  dfd_pkg::item_t item_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign item_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (valid_i && ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

/* design/dfd_parser.sv */
// Frame parser: phase tracking, header assembly and the verdict for each byte.
// Depends on dfd_pkg for the item, result, phase and status types.
module dfd_parser (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  dfd_pkg::item_t item_i,
  input  dfd_pkg::cfg_t  cfg_i,
  output logic           res_valid_o,
  output dfd_pkg::res_t  res_o
);

  dfd_pkg::phase_e phase_q, phase_d;
  logic [2:0]      hidx_q, hidx_d;
  logic [31:0]     stamp_q, stamp_d;
  logic [15:0]     len_q, len_d;
  logic [15:0]     left_q, left_d;

  logic [7:0]  b;
  logic        last;
  logic [15:0] left_dec;
  logic [15:0] len_hi;

  assign b        = item_i.data_byte;
  assign last     = item_i.buffer_end;
  assign left_dec = left_q - 16'd1;
  assign len_hi   = len_q | {b, 8'h00};

  always_comb begin
    phase_d = phase_q;
    hidx_d  = hidx_q;
    stamp_d = stamp_q;
    len_d   = len_q;
    left_d  = left_q;
    res_valid_o = 1'b0;
    res_o = '{kind: dfd_pkg::KIND_STATUS, payload_byte: 8'h00, status: dfd_pkg::ST_OK,
              stamp: 32'h0, payload_length: 16'h0};
    case (phase_q)
      dfd_pkg::PH_START: begin
        hidx_d  = 3'd0;
        stamp_d = 32'h0;
        len_d   = 16'h0;
        left_d  = 16'h0;
        if (b != cfg_i.start_value) begin
          res_valid_o  = 1'b1;
          res_o.status = dfd_pkg::ST_BAD_START;
          phase_d      = last ? dfd_pkg::PH_START : dfd_pkg::PH_IGNORE;
        end else if (last) begin
          res_valid_o  = 1'b1;
          res_o.status = dfd_pkg::ST_SHORT;
          phase_d      = dfd_pkg::PH_START;
        end else begin
          phase_d = dfd_pkg::PH_HEADER;
        end
      end
      dfd_pkg::PH_HEADER: begin
        if (last) begin
          res_valid_o  = 1'b1;
          res_o.status = dfd_pkg::ST_SHORT;
          phase_d      = dfd_pkg::PH_START;
        end else begin
          if (!hidx_q[2]) begin
            // Timestamp bytes arrive low byte first.
            case (hidx_q[1:0])
              2'd0:    stamp_d = stamp_q | {24'h0, b};
              2'd1:    stamp_d = stamp_q | {16'h0, b, 8'h00};
              2'd2:    stamp_d = stamp_q | {8'h00, b, 16'h0};
              default: stamp_d = stamp_q | {b, 24'h0};
            endcase
          end else if (hidx_q == 3'd4) begin
            len_d = {8'h00, b};
          end else begin
            len_d = len_hi;
          end
          if (hidx_q >= 3'd5) begin
            hidx_d  = 3'd0;
            left_d  = len_hi;
            phase_d = (len_hi == 16'h0) ? dfd_pkg::PH_END : dfd_pkg::PH_PAYLOAD;
          end else begin
            hidx_d = hidx_q + 3'd1;
          end
        end
      end
      dfd_pkg::PH_PAYLOAD: begin
        res_valid_o = 1'b1;
        if (last) begin
          res_o.status = dfd_pkg::ST_SHORT;
          phase_d      = dfd_pkg::PH_START;
        end else begin
          left_d = left_dec;
          if (left_dec == 16'h0) begin
            phase_d = dfd_pkg::PH_END;
          end
          res_o.kind         = dfd_pkg::KIND_PAYLOAD;
          res_o.payload_byte = b;
        end
      end
      dfd_pkg::PH_END: begin
        res_valid_o = 1'b1;
        phase_d     = last ? dfd_pkg::PH_START : dfd_pkg::PH_IGNORE;
        if (b == cfg_i.end_value) begin
          res_o.status         = dfd_pkg::ST_OK;
          res_o.stamp          = stamp_q;
          res_o.payload_length = len_q;
        end else begin
          res_o.status = dfd_pkg::ST_BAD_END;
        end
      end
      default: begin
        if (last) begin
          phase_d = dfd_pkg::PH_START;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dfd_pkg::PH_START;
      hidx_q  <= 3'd0;
      stamp_q <= 32'h0;
      len_q   <= 16'h0;
      left_q  <= 16'h0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hidx_q  <= hidx_d;
      stamp_q <= stamp_d;
      len_q   <= len_d;
      left_q  <= left_d;
    end
  end

endmodule

/* design/dfd_out_stage.sv */
// Result register of the deframer: holds one result until the sink takes it.
// Depends on dfd_pkg for the result type.
module dfd_out_stage (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          load_i,
  input  logic          res_valid_i,
  input  dfd_pkg::res_t res_i,
  output logic          ready_o,
  output logic          valid_o,
  input  logic          take_i,
  output dfd_pkg::res_t res_o
);

  logic          valid_q;
  dfd_pkg::res_t res_q;

  assign ready_o = !valid_q || take_i;
  assign valid_o = valid_q;
  assign res_o   = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= load_i && res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

/* design/delimited_frame_deframer_core.sv */
// Top level of the delimited frame deframer: input register, parser, result register.
// Depends on dfd_pkg, dfd_in_stage, dfd_parser and dfd_out_stage.
//
//   channel | direction | signals                         | payload
//   --------+-----------+---------------------------------+-------------------------------
//   s_axis  | in        | tvalid tready tdata tlast       | tdata: data_byte; tlast: end
//   m_axis  | out       | tvalid tready tdata tuser       | tuser: kind; tdata: see port
//   cfg     | in        | cfg_valid_i cfg_ready_o idx dat | register index and write data
//
// A byte sits in the input register while the parser works on it, and its result is loaded
// into the result register when the parser steps; a full result register holds the byte
// in the input register until the result register has room.
// One byte is taken per cycle as long as the sink keeps up; the parser step of one byte
// per cycle, gated by room in the result register, sets that rate.
// Reset puts the phase at START and clears the header fields, both valid flags and the config.
// When the sink stalls, one more byte is taken into the input register, then the input
// stalls until the result register drains.

module delimited_frame_deframer_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Input stream.
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [7:0]                          s_axis_tdata,   // [7:0] data_byte
  input  logic                                s_axis_tlast,   // buffer_end
  // Result stream.
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // [7:0] payload_byte, [9:8] status, [41:10] stamp, [57:42] payload_length, [63:58] zero
  output logic [dfd_pkg::OutDataW-1:0]        m_axis_tdata,
  output logic [0:0]                          m_axis_tuser,   // [0] kind
  // Configuration write channel.
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [dfd_pkg::CfgIdxW-1:0]         cfg_index_i,
  input  logic [7:0]                          cfg_data_i
);

  dfd_pkg::cfg_t  cfg_q;
  dfd_pkg::item_t in_item;
  dfd_pkg::item_t cur_item;
  dfd_pkg::res_t  par_res;
  dfd_pkg::res_t  out_res;
  logic           cur_valid;
  logic           par_res_valid;
  logic           out_ready;
  logic           step;

  // Configuration writes are always taken; an unknown index is dropped.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        dfd_pkg::CFG_START_VALUE: cfg_q.start_value <= cfg_data_i;
        dfd_pkg::CFG_END_VALUE:   cfg_q.end_value   <= cfg_data_i;
        default:                  cfg_q             <= cfg_q;
      endcase
    end
  end

  assign in_item.data_byte  = s_axis_tdata;
  assign in_item.buffer_end = s_axis_tlast;

  // The parser steps whenever a byte is waiting and the result register has room,
  // whether or not this byte produces a result.
  assign step = cur_valid && out_ready;

  dfd_in_stage u_in (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .item_i  (in_item),
    .valid_o (cur_valid),
    .take_i  (step),
    .item_o  (cur_item)
  );

  dfd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (step),
    .item_i      (cur_item),
    .cfg_i       (cfg_q),
    .res_valid_o (par_res_valid),
    .res_o       (par_res)
  );

  dfd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (step),
    .res_valid_i (par_res_valid),
    .res_i       (par_res),
    .ready_o     (out_ready),
    .valid_o     (m_axis_tvalid),
    .take_i      (m_axis_tready),
    .res_o       (out_res)
  );

  assign m_axis_tuser[0] = out_res.kind;
  assign m_axis_tdata = {6'b000000, out_res.payload_length, out_res.stamp, out_res.status,
                         out_res.payload_byte};

endmodule

/* design/dfd_checker.sv */
// Port-level checks for the deframer top level, attached through a bind.
// Depends on dfd_pkg and on the ports of delimited_frame_deframer_core.
module dfd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tvalid,
  input logic                         s_axis_tready,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [dfd_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [0:0]                   m_axis_tuser
);

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result changed while stalled");

  // A payload result carries only its byte.
  a_payload_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[0] == dfd_pkg::KIND_PAYLOAD) |->
      m_axis_tdata[63:8] == 56'h0)
    else $error("payload result carries status fields");

  // A failing status carries no timestamp, length or byte.
  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[0] == dfd_pkg::KIND_STATUS) &&
      (m_axis_tdata[9:8] != dfd_pkg::ST_OK) |->
      (m_axis_tdata[63:10] == 54'h0) && (m_axis_tdata[7:0] == 8'h00))
    else $error("failing status carries header fields");

  // The input side never stalls while no byte is offered and no result is pending.
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tvalid && !m_axis_tvalid |=> s_axis_tready)
    else $error("input stalled with nothing in flight");

endmodule

bind delimited_frame_deframer_core dfd_checker u_dfd_checker (.*);
